FILE: design/ctld_pkg.sv
`timescale 1ns / 1ps
package ctld_pkg;

  localparam int INPUT_DEPTH  = 2048;
  localparam int OUTPUT_DEPTH = 16384;
  localparam int LINE_DEPTH   = 512;

  localparam int IAW = $clog2(INPUT_DEPTH);
  localparam int OAW = $clog2(OUTPUT_DEPTH);
  localparam int LAW = $clog2(LINE_DEPTH);

  localparam int EMIT_MAX = 5;
  localparam int EMW      = $clog2(EMIT_MAX + 1);

  localparam int FLAG_CANON  = 0;
  localparam int FLAG_ECHO   = 1;
  localparam int FLAG_ECHONL = 2;
  localparam int FLAG_SIG    = 3;
  localparam int FLAG_CRLF   = 4;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] UTF_CONT_MASK = 8'hC0;
  localparam logic [7:0] UTF_CONT      = 8'h80;

  localparam logic [3:0] SK_NONE    = 4'd0;
  localparam logic [3:0] SK_LEFT    = 4'd4;
  localparam logic [3:0] SK_PGDN    = 4'd9;
  localparam logic [3:0] SK_F1      = 4'd10;
  localparam logic [3:0] SK_INVALID = 4'd15;

  localparam logic [7:0] MODE_RESET = 8'd27;
  localparam logic [7:0] INTR_RESET = 8'd3;
  localparam logic [7:0] QUIT_RESET = 8'd28;
  localparam logic [7:0] ERASE_RESET = 8'd127;
  localparam logic [7:0] KILL_RESET = 8'd21;
  localparam logic [7:0] EOF_RESET  = 8'd4;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_RD_IN  = 2'd1,
    OP_WR_OUT = 2'd2,
    OP_RD_OUT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_EOF   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_INT  = 2'd1,
    SIG_QUIT = 2'd2
  } sig_e;

  typedef enum logic [2:0] {
    CFG_MODE  = 3'd0,
    CFG_INTR  = 3'd1,
    CFG_QUIT  = 3'd2,
    CFG_ERASE = 3'd3,
    CFG_KILL  = 3'd4,
    CFG_EOF   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EMIT, S_HRD, S_HWR, S_DRD, S_DCK, S_RDIN, S_RDOUT, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    ACT_NONE, ACT_ERASE, ACT_KILL, ACT_NL
  } act_e;

  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] intr;
    logic [7:0] quit;
    logic [7:0] erase;
    logic [7:0] kill;
    logic [7:0] eof;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key;
    logic [3:0] sk;
    logic [7:0] wb;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       line_end;
    logic [1:0] sig;
    logic       input_ready;
    logic       output_pending;
  } res_t;

  typedef struct packed {
    logic           we;
    logic [IAW-1:0] waddr;
    logic [7:0]     wdata;
    logic [IAW-1:0] raddr;
  } in_req_t;

  typedef struct packed {
    logic           we;
    logic [OAW-1:0] waddr;
    logic [7:0]     wdata;
    logic [OAW-1:0] raddr;
  } out_req_t;

  typedef struct packed {
    logic           we;
    logic [LAW-1:0] waddr;
    logic [7:0]     wdata;
    logic [LAW-1:0] raddr;
  } line_req_t;

  function automatic logic [IAW-1:0] in_next(logic [IAW-1:0] p);
    return (p == IAW'(INPUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [OAW-1:0] out_next(logic [OAW-1:0] p);
    return (p == OAW'(OUTPUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [7:0] sk_digit(logic [3:0] sk);
    logic [7:0] d;
    unique case (sk)
      4'd5:    d = 8'h31;
      4'd6:    d = 8'h34;
      4'd7:    d = 8'h33;
      4'd8:    d = 8'h35;
      4'd9:    d = 8'h36;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

  function automatic logic [15:0] cp_box(logic [5:0] i);
    logic [15:0] v;
    unique case (i)
      6'd0:  v = 16'h2591; 6'd1:  v = 16'h2592; 6'd2:  v = 16'h2593; 6'd3:  v = 16'h2502;
      6'd4:  v = 16'h2524; 6'd5:  v = 16'h2561; 6'd6:  v = 16'h2562; 6'd7:  v = 16'h2556;
      6'd8:  v = 16'h2555; 6'd9:  v = 16'h2563; 6'd10: v = 16'h2551; 6'd11: v = 16'h2557;
      6'd12: v = 16'h255D; 6'd13: v = 16'h255C; 6'd14: v = 16'h255B; 6'd15: v = 16'h2510;
      6'd16: v = 16'h2514; 6'd17: v = 16'h2534; 6'd18: v = 16'h252C; 6'd19: v = 16'h251C;
      6'd20: v = 16'h2500; 6'd21: v = 16'h253C; 6'd22: v = 16'h255E; 6'd23: v = 16'h255F;
      6'd24: v = 16'h255A; 6'd25: v = 16'h2554; 6'd26: v = 16'h2569; 6'd27: v = 16'h2566;
      6'd28: v = 16'h2560; 6'd29: v = 16'h2550; 6'd30: v = 16'h256C; 6'd31: v = 16'h2567;
      6'd32: v = 16'h2568; 6'd33: v = 16'h2564; 6'd34: v = 16'h2565; 6'd35: v = 16'h2559;
      6'd36: v = 16'h2558; 6'd37: v = 16'h2552; 6'd38: v = 16'h2553; 6'd39: v = 16'h256B;
      6'd40: v = 16'h256A; 6'd41: v = 16'h2518; 6'd42: v = 16'h250C; 6'd43: v = 16'h2588;
      6'd44: v = 16'h2584; 6'd45: v = 16'h258C; 6'd46: v = 16'h2590; 6'd47: v = 16'h2580;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] cp_tail(logic [3:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0:  v = 16'h0401; 4'd1:  v = 16'h0451; 4'd2:  v = 16'h0404; 4'd3:  v = 16'h0454;
      4'd4:  v = 16'h0407; 4'd5:  v = 16'h0457; 4'd6:  v = 16'h040E; 4'd7:  v = 16'h045E;
      4'd8:  v = 16'h00B0; 4'd9:  v = 16'h2219; 4'd10: v = 16'h00B7; 4'd11: v = 16'h221A;
      4'd12: v = 16'h2116; 4'd13: v = 16'h00A4; 4'd14: v = 16'h25A0; 4'd15: v = 16'h00A0;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  // code point of a CP866 byte from 0x80 up
  function automatic logic [15:0] cp866_code(logic [7:0] c);
    logic [15:0] v;
    logic [7:0]  boff;
    boff = c - 8'hB0;
    if (c < 8'hB0) begin
      v = 16'h0410 + {8'h00, c - 8'h80};
    end else if (c < 8'hE0) begin
      v = cp_box(boff[5:0]);
    end else if (c < 8'hF0) begin
      v = 16'h0440 + {8'h00, c - 8'hE0};
    end else begin
      v = cp_tail(c[3:0]);
    end
    return v;
  endfunction

endpackage

FILE: design/ctld_if.sv
`timescale 1ns / 1ps
interface ctld_in_if import ctld_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] key_byte;
  logic [3:0] special_key;
  logic [7:0] write_byte;

  modport source (output valid, op, key_byte, special_key, write_byte, input ready);
  modport sink (input valid, op, key_byte, special_key, write_byte, output ready);
endinterface

interface ctld_out_if import ctld_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_byte;
  logic       line_end;
  logic [1:0] signal_code;
  logic       input_ready;
  logic       output_pending;

  modport source (output valid, status, data_byte, line_end, signal_code, input_ready,
                  output_pending, input ready);
  modport sink (input valid, status, data_byte, line_end, signal_code, input_ready,
                output_pending, output ready);
endinterface

interface ctld_cfg_if import ctld_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/canonical_tty_line_discipline.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_i     in   op, key_byte, special_key, write_byte
// out_o    out  status, data_byte, line_end, signal_code, input_ready, output_pending
// cfg_i    in   index (0..5), data
//
// One item at a time: a new item is taken only once the last result is handed on.
// A line hand-over reads each edit-line byte from the line RAM, then writes it to
// the input ring; erase and kill drop the bytes of each character and then rub it
// out (the rubout is echoed only with echo on).
// Reset clears pointers, edit length and the end-of-file mark; no clearing pass.
// A result waits in the output register while the next item is taken.
module canonical_tty_line_discipline import ctld_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ctld_in_if.sink      in_i,
  ctld_out_if.source   out_o,
  ctld_cfg_if.sink     cfg_i
);
  cfg_t      cfg_q;
  item_t     item;
  res_t      res, res_q;
  logic      res_valid, res_ready, out_valid_q;
  in_req_t   in_req;
  out_req_t  out_req;
  line_req_t line_req;
  logic [7:0] in_rdata, out_rdata, line_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_RESET[4:0];
      cfg_q.intr  <= INTR_RESET;
      cfg_q.quit  <= QUIT_RESET;
      cfg_q.erase <= ERASE_RESET;
      cfg_q.kill  <= KILL_RESET;
      cfg_q.eof   <= EOF_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MODE:  cfg_q.mode  <= cfg_i.data[4:0];
        CFG_INTR:  cfg_q.intr  <= cfg_i.data;
        CFG_QUIT:  cfg_q.quit  <= cfg_i.data;
        CFG_ERASE: cfg_q.erase <= cfg_i.data;
        CFG_KILL:  cfg_q.kill  <= cfg_i.data;
        CFG_EOF:   cfg_q.eof   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign item.op = in_i.op;
  assign item.key = in_i.key_byte;
  assign item.sk = in_i.special_key;
  assign item.wb = in_i.write_byte;

  ctld_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (in_i.valid),
    .item_ready_o (in_i.ready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .in_req_o     (in_req),
    .in_rdata_i   (in_rdata),
    .out_req_o    (out_req),
    .out_rdata_i  (out_rdata),
    .line_req_o   (line_req),
    .line_rdata_i (line_rdata)
  );

  ctld_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH)) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_req.we),
    .waddr_i (in_req.waddr),
    .wdata_i (in_req.wdata),
    .raddr_i (in_req.raddr),
    .rdata_o (in_rdata)
  );

  ctld_ram #(.WIDTH(8), .DEPTH(OUTPUT_DEPTH)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_req.we),
    .waddr_i (out_req.waddr),
    .wdata_i (out_req.wdata),
    .raddr_i (out_req.raddr),
    .rdata_o (out_rdata)
  );

  ctld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_req.we),
    .waddr_i (line_req.waddr),
    .wdata_i (line_req.wdata),
    .raddr_i (line_req.raddr),
    .rdata_o (line_rdata)
  );

  // output register: hold the result until taken
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.data_byte      = res_q.data;
  assign out_o.line_end       = res_q.line_end;
  assign out_o.signal_code    = res_q.sig;
  assign out_o.input_ready    = res_q.input_ready;
  assign out_o.output_pending = res_q.output_pending;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("item accepted while another is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_FULL |-> out_o.output_pending)
    else $error("full status with empty output ring");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.line_end |-> out_o.data_byte == CH_LF && out_o.status == ST_OK)
    else $error("line end on a non-newline byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.signal_code != SIG_NONE |-> out_o.status == ST_OK &&
    out_o.data_byte == 8'h00)
    else $error("signal raised with data or error status");
endmodule

FILE: design/ctld_ram.sv
`timescale 1ns / 1ps
module ctld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/ctld_utf8.sv
`timescale 1ns / 1ps
module ctld_utf8 import ctld_pkg::*; (
  input  logic [7:0]      char_i,
  output logic [2:0][7:0] bytes_o,
  output logic [1:0]      count_o
);
  logic [15:0] cp;

  assign cp = cp866_code(char_i);

  always_comb begin
    bytes_o = '0;
    count_o = 2'd1;
    if (char_i < 8'h80) begin
      bytes_o[0] = char_i;
    end else if (cp < 16'h0800) begin
      bytes_o[0] = 8'hC0 | {3'b000, cp[10:6]};
      bytes_o[1] = 8'h80 | {2'b00, cp[5:0]};
      count_o    = 2'd2;
    end else begin
      bytes_o[0] = 8'hE0 | {4'h0, cp[15:12]};
      bytes_o[1] = 8'h80 | {2'b00, cp[11:6]};
      bytes_o[2] = 8'h80 | {2'b00, cp[5:0]};
      count_o    = 2'd3;
    end
  end
endmodule

FILE: design/ctld_seq.sv
`timescale 1ns / 1ps
module ctld_seq import ctld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  item_t      item_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_t       res_o,
  output in_req_t    in_req_o,
  input  logic [7:0] in_rdata_i,
  output out_req_t   out_req_o,
  input  logic [7:0] out_rdata_i,
  output line_req_t  line_req_o,
  input  logic [7:0] line_rdata_i
);
  state_e         state_q, state_d;
  act_e           act_q, act_d;
  item_t          item_q, item_d;
  logic [IAW-1:0] in_head_q, in_head_d, in_tail_q, in_tail_d;
  logic [OAW-1:0] out_head_q, out_head_d, out_tail_q, out_tail_d;
  logic [LAW-1:0] len_q, len_d, hidx_q, hidx_d;
  logic           eof_q, eof_d;
  logic [7:0]     emit_byte_q [EMIT_MAX];
  logic [7:0]     emit_byte_d [EMIT_MAX];
  logic [EMIT_MAX-1:0] emit_in_q, emit_in_d, emit_out_q, emit_out_d, emit_line_q, emit_line_d;
  logic [EMW-1:0] emit_cnt_q, emit_cnt_d, emit_idx_q, emit_idx_d;
  status_e        status_q, status_d;
  logic [7:0]     data_q, data_d;
  logic           lend_q, lend_d;
  logic [1:0]     sig_q, sig_d;

  logic [7:0]      c1, c2, ch;
  logic [2:0][7:0] u8;
  logic [1:0]      nu;
  logic            canon, echo_on, in_full, out_full, fits;
  logic [LAW+1:0]  fill;

  assign canon    = cfg_i.mode[FLAG_CANON];
  assign echo_on  = cfg_i.mode[FLAG_ECHO];
  assign in_full  = (in_next(in_head_q) == in_tail_q);
  assign out_full = (out_next(out_head_q) == out_tail_q);

  // key mapping: backspace to DEL, Enter to CR, then CR to LF when enabled
  assign c1 = (item_q.key == CH_BS) ? CH_DEL : item_q.key;
  assign c2 = (c1 == CH_LF) ? CH_CR : c1;
  assign ch = (c2 == CH_CR && cfg_i.mode[FLAG_CRLF]) ? CH_LF : c2;

  ctld_utf8 u_utf8 (
    .char_i  (ch),
    .bytes_o (u8),
    .count_o (nu)
  );

  assign fill = {2'b00, len_q} + (LAW+2)'(nu);
  assign fits = (fill < (LAW+2)'(LINE_DEPTH));

  assign item_ready_o = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_FIN);

  always_comb begin
    res_o.status         = status_q;
    res_o.data           = data_q;
    res_o.line_end       = lend_q;
    res_o.sig            = sig_q;
    res_o.input_ready    = (in_head_q != in_tail_q) || eof_q;
    res_o.output_pending = (out_head_q != out_tail_q);
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    item_d      = item_q;
    in_head_d   = in_head_q;
    in_tail_d   = in_tail_q;
    out_head_d  = out_head_q;
    out_tail_d  = out_tail_q;
    len_d       = len_q;
    hidx_d      = hidx_q;
    eof_d       = eof_q;
    emit_byte_d = emit_byte_q;
    emit_in_d   = emit_in_q;
    emit_out_d  = emit_out_q;
    emit_line_d = emit_line_q;
    emit_cnt_d  = emit_cnt_q;
    emit_idx_d  = emit_idx_q;
    status_d    = status_q;
    data_d      = data_q;
    lend_d      = lend_q;
    sig_d       = sig_q;

    in_req_o.we      = 1'b0;
    in_req_o.waddr   = in_head_q;
    in_req_o.wdata   = '0;
    in_req_o.raddr   = in_tail_q;
    out_req_o.we     = 1'b0;
    out_req_o.waddr  = out_head_q;
    out_req_o.wdata  = item_q.wb;
    out_req_o.raddr  = out_tail_q;
    line_req_o.we    = 1'b0;
    line_req_o.waddr = len_q;
    line_req_o.wdata = '0;
    line_req_o.raddr = (state_q == S_DRD) ? len_q - 1'b1 : hidx_q;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_d   = item_i;
          status_d = ST_OK;
          data_d   = '0;
          lend_d   = 1'b0;
          sig_d    = SIG_NONE;
          act_d    = ACT_NONE;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        emit_idx_d  = '0;
        emit_cnt_d  = '0;
        emit_in_d   = '0;
        emit_out_d  = '0;
        emit_line_d = '0;
        state_d     = S_FIN;
        unique case (op_e'(item_q.op))
          OP_KEY: begin
            if (item_q.sk == SK_INVALID) begin
              state_d = S_FIN;
            end else if (item_q.sk != SK_NONE) begin
              if (!canon) begin
                // escape sequence straight to the input ring
                emit_byte_d[0] = CH_ESC;
                emit_byte_d[1] = CH_LBR;
                emit_in_d      = '1;
                if (item_q.sk <= SK_LEFT) begin
                  emit_byte_d[2] = CH_A + {4'h0, item_q.sk} - 8'd1;
                  emit_cnt_d     = EMW'(3);
                end else if (item_q.sk <= SK_PGDN) begin
                  emit_byte_d[2] = sk_digit(item_q.sk);
                  emit_byte_d[3] = CH_TILDE;
                  emit_cnt_d     = EMW'(4);
                end else begin
                  emit_byte_d[2] = CH_LBR;
                  emit_byte_d[3] = CH_A + {4'h0, item_q.sk - SK_F1};
                  emit_cnt_d     = EMW'(4);
                end
                state_d = S_EMIT;
              end
            end else if (cfg_i.mode[FLAG_SIG] && (ch == cfg_i.intr || ch == cfg_i.quit)) begin
              len_d          = '0;
              sig_d          = (ch == cfg_i.intr) ? SIG_INT : SIG_QUIT;
              emit_byte_d[0] = CH_CARET;
              emit_byte_d[1] = (ch == CH_ETX) ? CH_C : CH_BSL;
              emit_byte_d[2] = CH_LF;
              emit_out_d     = '1;
              emit_cnt_d     = echo_on ? EMW'(3) : '0;
              state_d        = S_EMIT;
            end else if (!canon) begin
              for (int i = 0; i < 3; i++) begin
                emit_byte_d[i] = u8[i];
              end
              emit_in_d  = '1;
              emit_out_d = echo_on ? '1 : '0;
              emit_cnt_d = EMW'(nu);
              state_d    = S_EMIT;
            end else if (ch == cfg_i.erase || ch == CH_DEL) begin
              if (len_q != '0) begin
                act_d   = ACT_ERASE;
                state_d = S_DRD;
              end
            end else if (ch == cfg_i.kill) begin
              act_d   = ACT_KILL;
              state_d = S_DRD;
            end else if (ch == cfg_i.eof) begin
              if (len_q == '0) begin
                eof_d = 1'b1;
              end
              hidx_d  = '0;
              state_d = S_HRD;
            end else if (ch == CH_LF) begin
              act_d   = ACT_NL;
              hidx_d  = '0;
              state_d = S_HRD;
            end else if (ch >= CH_SP && ch != CH_DEL && fits) begin
              for (int i = 0; i < 3; i++) begin
                emit_byte_d[i] = u8[i];
              end
              emit_line_d = '1;
              emit_out_d  = echo_on ? '1 : '0;
              emit_cnt_d  = EMW'(nu);
              state_d     = S_EMIT;
            end
          end
          OP_RD_IN: begin
            if (in_head_q != in_tail_q) begin
              state_d = S_RDIN;
            end else if (eof_q) begin
              eof_d    = 1'b0;
              status_d = ST_EOF;
            end else begin
              status_d = ST_EMPTY;
            end
          end
          OP_WR_OUT: begin
            if (!out_full) begin
              out_req_o.we = 1'b1;
              out_head_d   = out_next(out_head_q);
            end else begin
              status_d = ST_FULL;
            end
          end
          OP_RD_OUT: begin
            if (out_head_q != out_tail_q) begin
              state_d = S_RDOUT;
            end else begin
              status_d = ST_EMPTY;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_EMIT: begin
        if (emit_idx_q == emit_cnt_q) begin
          state_d = (act_q == ACT_KILL && len_q != '0) ? S_DRD : S_FIN;
        end else begin
          // one list entry per cycle; full rings drop it
          if (emit_in_q[emit_idx_q] && !in_full) begin
            in_req_o.we    = 1'b1;
            in_req_o.wdata = emit_byte_q[emit_idx_q];
            in_head_d      = in_next(in_head_q);
          end
          if (emit_out_q[emit_idx_q] && !out_full) begin
            out_req_o.we    = 1'b1;
            out_req_o.wdata = emit_byte_q[emit_idx_q];
            out_head_d      = out_next(out_head_q);
          end
          if (emit_line_q[emit_idx_q]) begin
            line_req_o.we    = 1'b1;
            line_req_o.wdata = emit_byte_q[emit_idx_q];
            len_d            = len_q + 1'b1;
          end
          emit_idx_d = emit_idx_q + 1'b1;
        end
      end
      S_HRD: begin
        if (hidx_q == len_q) begin
          len_d = '0;
          if (act_q == ACT_NL) begin
            act_d          = ACT_NONE;
            emit_byte_d[0] = CH_LF;
            emit_in_d      = EMIT_MAX'(1);
            emit_out_d     = (echo_on || cfg_i.mode[FLAG_ECHONL]) ? EMIT_MAX'(1) : '0;
            emit_line_d    = '0;
            emit_idx_d     = '0;
            emit_cnt_d     = EMW'(1);
            state_d        = S_EMIT;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_HWR;
        end
      end
      S_HWR: begin
        if (!in_full) begin
          in_req_o.we    = 1'b1;
          in_req_o.wdata = line_rdata_i;
          in_head_d      = in_next(in_head_q);
        end
        hidx_d  = hidx_q + 1'b1;
        state_d = S_HRD;
      end
      S_DRD: begin
        // rubout list for the character being dropped
        emit_byte_d[0] = CH_BS;
        emit_byte_d[1] = CH_SP;
        emit_byte_d[2] = CH_BS;
        emit_in_d      = '0;
        emit_out_d     = '1;
        emit_line_d    = '0;
        emit_idx_d     = '0;
        emit_cnt_d     = echo_on ? EMW'(3) : '0;
        if (len_q == '0) begin
          state_d = S_FIN;
        end else if (len_q == LAW'(1)) begin
          len_d   = '0;
          state_d = S_EMIT;
        end else begin
          state_d = S_DCK;
        end
      end
      S_DCK: begin
        len_d   = len_q - 1'b1;
        state_d = ((line_rdata_i & UTF_CONT_MASK) == UTF_CONT) ? S_DRD : S_EMIT;
      end
      S_RDIN: begin
        data_d    = in_rdata_i;
        lend_d    = canon && (in_rdata_i == CH_LF);
        in_tail_d = in_next(in_tail_q);
        state_d   = S_FIN;
      end
      S_RDOUT: begin
        data_d     = out_rdata_i;
        out_tail_d = out_next(out_tail_q);
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      act_q      <= ACT_NONE;
      in_head_q  <= '0;
      in_tail_q  <= '0;
      out_head_q <= '0;
      out_tail_q <= '0;
      len_q      <= '0;
      eof_q      <= 1'b0;
      emit_cnt_q <= '0;
      emit_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      act_q      <= act_d;
      in_head_q  <= in_head_d;
      in_tail_q  <= in_tail_d;
      out_head_q <= out_head_d;
      out_tail_q <= out_tail_d;
      len_q      <= len_d;
      eof_q      <= eof_d;
      emit_cnt_q <= emit_cnt_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    hidx_q      <= hidx_d;
    emit_byte_q <= emit_byte_d;
    emit_in_q   <= emit_in_d;
    emit_out_q  <= emit_out_d;
    emit_line_q <= emit_line_d;
    status_q    <= status_d;
    data_q      <= data_d;
    lend_q      <= lend_d;
    sig_q       <= sig_d;
  end
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ctld_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ctld_in_if  in_ch ();
  ctld_out_if out_ch ();
  ctld_cfg_if cfg_ch ();

  canonical_tty_line_discipline dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state
  logic [7:0]  in_mem [INPUT_DEPTH];
  logic [7:0]  out_mem [OUTPUT_DEPTH];
  logic [7:0]  line_mem [LINE_DEPTH];
  int unsigned in_wp, in_rp, out_wp, out_rp, edit_cnt;
  bit          eof_flag;
  cfg_t        regs;

  item_t pending_items[$];
  res_t  expected_res[$];
  int    errors;
  int    send_idle_pct, recv_stall_pct;
  bit    drained_pause;

  function automatic void in_push(logic [7:0] b);
    int unsigned n;
    n = (in_wp + 1 >= INPUT_DEPTH) ? 0 : in_wp + 1;
    if (n == in_rp) return;
    in_mem[in_wp] = b;
    in_wp = n;
  endfunction

  function automatic bit echo_push(logic [7:0] b);
    int unsigned n;
    n = (out_wp + 1 >= OUTPUT_DEPTH) ? 0 : out_wp + 1;
    if (n == out_rp) return 1'b0;
    out_mem[out_wp] = b;
    out_wp = n;
    return 1'b1;
  endfunction

  function automatic void rubout();
    void'(echo_push(CH_BS)); void'(echo_push(CH_SP)); void'(echo_push(CH_BS));
  endfunction

  function automatic void drop_char();
    while (edit_cnt > 1 && (line_mem[edit_cnt - 1] & 8'hC0) == 8'h80) edit_cnt--;
    if (edit_cnt > 0) edit_cnt--;
  endfunction

  function automatic void flush_line();
    for (int i = 0; i < edit_cnt; i++) in_push(line_mem[i]);
    edit_cnt = 0;
  endfunction

  function automatic logic [15:0] box_code(int i);
    logic [15:0] t [48] = '{
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
      16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
      16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
      16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580};
    return t[i];
  endfunction

  function automatic logic [15:0] tail_code(int i);
    logic [15:0] t [16] = '{
      16'h0401, 16'h0451, 16'h0404, 16'h0454, 16'h0407, 16'h0457, 16'h040E, 16'h045E,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h2116, 16'h00A4, 16'h25A0, 16'h00A0};
    return t[i];
  endfunction

  function automatic logic [1:0] press_key(logic [7:0] c, logic [3:0] sk);
    bit canon, echo_on;
    logic [7:0] u [3];
    int nu;
    logic [15:0] cp;
    logic [7:0] digits [5] = '{8'h31, 8'h34, 8'h33, 8'h35, 8'h36};
    canon = regs.mode[FLAG_CANON];
    echo_on = regs.mode[FLAG_ECHO];
    nu = 1;
    if (sk == SK_INVALID) return SIG_NONE;
    if (sk != SK_NONE) begin
      if (canon) return SIG_NONE;
      in_push(CH_ESC); in_push(CH_LBR);
      if (sk <= SK_LEFT) begin
        in_push(CH_A + 8'(sk - 1));
      end else if (sk <= SK_PGDN) begin
        in_push(digits[sk - 5]); in_push(CH_TILDE);
      end else begin
        in_push(CH_LBR); in_push(CH_A + 8'(sk - SK_F1));
      end
      return SIG_NONE;
    end
    if (c == CH_BS) c = CH_DEL;
    if (c == CH_LF) c = CH_CR;
    if (c == CH_CR && regs.mode[FLAG_CRLF]) c = CH_LF;
    if (regs.mode[FLAG_SIG] && (c == regs.intr || c == regs.quit)) begin
      edit_cnt = 0;
      if (echo_on) begin
        void'(echo_push(CH_CARET));
        void'(echo_push(c == CH_ETX ? CH_C : CH_BSL));
        void'(echo_push(CH_LF));
      end
      return (c == regs.intr) ? SIG_INT : SIG_QUIT;
    end
    u[0] = c;
    if (c >= 8'h80) begin
      if (c < 8'hB0) cp = 16'h0410 + 16'(c - 8'h80);
      else if (c < 8'hE0) cp = box_code(c - 8'hB0);
      else if (c < 8'hF0) cp = 16'h0440 + 16'(c - 8'hE0);
      else cp = tail_code(c[3:0]);
      if (cp < 16'h0800) begin
        u[0] = 8'hC0 | 8'(cp >> 6);
        u[1] = 8'h80 | 8'(cp & 16'h3F);
        nu = 2;
      end else begin
        u[0] = 8'hE0 | 8'((cp >> 12) & 16'hF);
        u[1] = 8'h80 | 8'((cp >> 6) & 16'h3F);
        u[2] = 8'h80 | 8'(cp & 16'h3F);
        nu = 3;
      end
    end
    if (!canon) begin
      for (int i = 0; i < nu; i++) begin
        in_push(u[i]);
        if (echo_on) void'(echo_push(u[i]));
      end
      return SIG_NONE;
    end
    if (c == regs.erase || c == CH_DEL) begin
      if (edit_cnt > 0) begin
        drop_char();
        if (echo_on) rubout();
      end
    end else if (c == regs.kill) begin
      while (edit_cnt > 0) begin
        drop_char();
        if (echo_on) rubout();
      end
    end else if (c == regs.eof) begin
      if (edit_cnt == 0) eof_flag = 1'b1;
      flush_line();
    end else if (c == CH_LF) begin
      flush_line();
      in_push(CH_LF);
      if (echo_on || regs.mode[FLAG_ECHONL]) void'(echo_push(CH_LF));
    end else if (c >= CH_SP && c != CH_DEL && edit_cnt + nu < LINE_DEPTH) begin
      for (int i = 0; i < nu; i++) begin
        line_mem[edit_cnt] = u[i];
        edit_cnt++;
        if (echo_on) void'(echo_push(u[i]));
      end
    end
    return SIG_NONE;
  endfunction

  function automatic res_t predict_step(item_t it);
    res_t r;
    r = '0;
    r.status = ST_OK;
    case (op_e'(it.op))
      OP_KEY: r.sig = press_key(it.key, it.sk);
      OP_RD_IN: begin
        if (in_wp != in_rp) begin
          r.data = in_mem[in_rp];
          in_rp = (in_rp + 1 >= INPUT_DEPTH) ? 0 : in_rp + 1;
          r.line_end = regs.mode[FLAG_CANON] && r.data == CH_LF;
        end else if (eof_flag) begin
          eof_flag = 1'b0;
          r.status = ST_EOF;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_WR_OUT: if (!echo_push(it.wb)) r.status = ST_FULL;
      default: begin
        if (out_wp != out_rp) begin
          r.data = out_mem[out_rp];
          out_rp = (out_rp + 1 >= OUTPUT_DEPTH) ? 0 : out_rp + 1;
        end else begin
          r.status = ST_EMPTY;
        end
      end
    endcase
    r.input_ready = (in_wp != in_rp) || eof_flag;
    r.output_pending = out_wp != out_rp;
    return r;
  endfunction

  // driver
  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0; in_ch.key_byte = '0; in_ch.special_key = '0; in_ch.write_byte = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(predict_step(item_t'({in_ch.op, in_ch.key_byte,
                                                      in_ch.special_key, in_ch.write_byte})));
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_items.size() > 0 && !drained_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          item_t it;
          it = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= it.op;
          in_ch.key_byte <= it.key;
          in_ch.special_key <= it.sk;
          in_ch.write_byte <= it.wb;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      res_t got, want;
      got = {status_e'(out_ch.status), out_ch.data_byte, out_ch.line_end, out_ch.signal_code,
             out_ch.input_ready, out_ch.output_pending};
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected st=%0d d=%h le=%b sg=%0d ir=%b op=%b",
                   $time, want.status, want.data, want.line_end, want.sig,
                   want.input_ready, want.output_pending);
          $display("%0t:          actual   st=%0d d=%h le=%b sg=%0d ir=%b op=%b",
                   $time, got.status, got.data, got.line_end, got.sig,
                   got.input_ready, got.output_pending);
          errors++;
        end
      end
    end
  end

  // watchdog
  int stuck_cycles;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || (pending_items.size() == 0 &&
        expected_res.size() == 0) || drained_pause)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles > 20000) begin
      $display("FAIL canonical_tty_line_discipline");
      $finish;
    end
  end

  function automatic item_t mk(op_e op, logic [7:0] key, logic [3:0] sk, logic [7:0] wb);
    item_t it;
    it.op = op; it.key = key; it.sk = sk; it.wb = wb;
    return it;
  endfunction

  function automatic item_t rand_item();
    int p;
    logic [7:0] k;
    p = $urandom_range(99);
    k = $urandom_range(255);
    if (p < 40) k = $urandom_range(8'h20, 8'h7E);
    else if (p < 50) k = $urandom_range(8'h80, 8'hFF);
    else if (p < 55) k = CH_CR;
    else if (p < 60) k = regs.erase;
    else if (p < 62) k = regs.kill;
    else if (p < 64) k = regs.eof;
    else if (p < 66) k = regs.intr;
    if (p < 68) return mk(OP_KEY, k, SK_NONE, 8'h00);
    if (p < 73) return mk(OP_KEY, k, 4'($urandom_range(15)), 8'h00);
    if (p < 84) return mk(OP_RD_IN, k, 4'($urandom_range(15)), 8'($urandom));
    if (p < 88) return mk(OP_WR_OUT, k, 4'($urandom_range(15)), 8'($urandom));
    return mk(OP_RD_OUT, k, 4'($urandom_range(15)), 8'($urandom));
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_res.size() > 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_MODE:  regs.mode = val[4:0];
      CFG_INTR:  regs.intr = val;
      CFG_QUIT:  regs.quit = val;
      CFG_ERASE: regs.erase = val;
      CFG_KILL:  regs.kill = val;
      default:   regs.eof = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
    wait_drained();
  endtask

  initial begin
    regs = {MODE_RESET[4:0], INTR_RESET, QUIT_RESET, ERASE_RESET, KILL_RESET, EOF_RESET};
    in_wp = 0; in_rp = 0; out_wp = 0; out_rp = 0; edit_cnt = 0; eof_flag = 0;
    errors = 0; send_idle_pct = 0; recv_stall_pct = 0; drained_pause = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: canonical line edit with multibyte chars, signals, eof, specials
    pending_items.push_back(mk(OP_RD_IN, 8'h00, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_RD_OUT, 8'hFF, 4'hF, 8'hFF));
    pending_items.push_back(mk(OP_KEY, 8'h41, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'hB0, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'hFF, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'h80, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, CH_BS, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, CH_DEL, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'h03, 4'd3, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'h42, 4'hF, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'hE5, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, CH_LF, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'h43, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'd21, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'd4, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'd3, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_KEY, 8'd28, SK_NONE, 8'h00));
    pending_items.push_back(mk(OP_WR_OUT, 8'h00, SK_NONE, 8'hFF));
    pending_items.push_back(mk(OP_WR_OUT, 8'h00, SK_NONE, 8'h00));
    for (int i = 0; i < 6; i++) pending_items.push_back(mk(OP_RD_IN, 8'h00, SK_NONE, 8'h00));
    wait_drained();

    // raw mode: every special key
    write_reg(CFG_MODE, 8'h02);
    for (int s = 0; s < 16; s++) pending_items.push_back(mk(OP_KEY, 8'h61, 4'(s), 8'h00));
    for (int i = 0; i < 8; i++) pending_items.push_back(mk(OP_KEY, 8'(i * 37), SK_NONE, 8'h00));
    for (int i = 0; i < 80; i++) pending_items.push_back(mk(OP_RD_IN, 8'h00, SK_NONE, 8'h00));
    for (int i = 0; i < 40; i++) pending_items.push_back(mk(OP_RD_OUT, 8'h00, SK_NONE, 8'h00));
    wait_drained();

    // canonical with default characters, idling phases
    write_reg(CFG_MODE, MODE_RESET);
    run_random(80);
    send_idle_pct = 51;
    run_random(70);
    send_idle_pct = 0; recv_stall_pct = 51;
    run_random(70);

    // hold the sender with an item queued, then release it and drain
    pending_items.push_back(mk(OP_KEY, 8'h5A, SK_NONE, 8'h00));
    drained_pause = 1'b1;
    repeat (50) @(posedge clk_i);
    drained_pause = 1'b0;
    wait_drained();

    // other settings, extremes among them
    send_idle_pct = 13; recv_stall_pct = 13;
    write_reg(CFG_MODE, 8'h1F);
    write_reg(CFG_INTR, 8'hFF);
    write_reg(CFG_QUIT, 8'h00);
    write_reg(CFG_ERASE, 8'h61);
    write_reg(CFG_KILL, 8'hFE);
    write_reg(CFG_EOF, 8'h7A);
    run_random(70);
    send_idle_pct = 0; recv_stall_pct = 0;
    write_reg(CFG_MODE, 8'h05);
    write_reg(CFG_INTR, 8'h03);
    write_reg(CFG_QUIT, 8'h1C);
    write_reg(CFG_ERASE, 8'h00);
    write_reg(CFG_KILL, 8'h15);
    write_reg(CFG_EOF, 8'h04);
    run_random(50);
    write_reg(CFG_MODE, 8'h00);
    run_random(40);

    if (errors == 0) begin
      $display("PASS canonical_tty_line_discipline");
    end else begin
      $display("FAIL canonical_tty_line_discipline");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ctld_pkg.sv
design/ctld_if.sv
design/ctld_ram.sv
design/ctld_utf8.sv
design/ctld_seq.sv
design/canonical_tty_line_discipline.sv
dv/tb_top.sv
